// File: src/dvs_pkg.sv
// ----------------------------------------------------------------------------
// dvs_pkg
// Shared request codes, status codes, cell control bundle and a small
// find-first helper for the deque with value search.
// ----------------------------------------------------------------------------
package dvs_pkg;

    // request codes on the kind port
    localparam logic [2:0] KIND_PUSH_TAIL = 3'd0;
    localparam logic [2:0] KIND_PUSH_HEAD = 3'd1;
    localparam logic [2:0] KIND_POP_HEAD  = 3'd2;
    localparam logic [2:0] KIND_POP_TAIL  = 3'd3;
    localparam logic [2:0] KIND_SEARCH    = 3'd4;

    // result status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // match flags examined per scan cycle
    localparam int unsigned SCAN_GROUP = 8;

    // control common to every cell of the chain
    typedef struct packed {
        logic shr;   // move every entry one cell towards the tail
        logic shl;   // move every entry one cell towards the head
        logic cap;   // capture the compare result against the key
    } dvs_ctrl_t;

    // index of the lowest set bit of an 8-bit group, 0 when none is set
    function automatic logic [2:0] first_set8(input logic [7:0] bits);
        logic [2:0] idx;
        idx = 3'd0;
        for (int k = 7; k >= 0; k--) begin
            if (bits[k]) begin
                idx = 3'(k);
            end
        end
        return idx;
    endfunction

endpackage

// File: src/deque_with_value_search_unit.sv
// Push, pop and unused codes: result strobe in the cycle after the accepting beat;
// busy stays low, so a new request may be started every cycle.
// Search: compare in all cells at the accepting edge, then a scan of the match
// flags in groups of 8, one group per cycle; busy high until the result strobe.
// Results cannot be stalled.
// Reset clears the entry count and control; stored entries are not cleared.
// ----------------------------------------------------------------------------
// deque_with_value_search_unit
// Bounded double-ended queue of signed 32-bit values held in a shifting chain
// of cells, with a first-match search reporting the position from the head.
// ----------------------------------------------------------------------------
module deque_with_value_search_unit
    import dvs_pkg::*;
#(
    parameter int unsigned DEPTH = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         kind,
    input  logic signed [31:0] value,
    output logic               done,
    output logic [1:0]         status,
    output logic               found,
    output logic [3:0]         found_position,
    output logic [4:0]         entry_count
);

    localparam int unsigned CW   = $clog2(DEPTH + 1);
    localparam int unsigned NGRP = (DEPTH + SCAN_GROUP - 1) / SCAN_GROUP;
    localparam int unsigned GW   = (NGRP > 1) ? $clog2(NGRP) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [GW-1:0]     grp_reg, grp_next;
    logic              done_reg, done_next;
    logic [1:0]        status_reg, status_next;
    logic              found_reg, found_next;
    logic [3:0]        pos_reg, pos_next;

    dvs_ctrl_t         ctrl;
    logic              tail_wr;
    logic              accept;
    logic [31:0]       key;
    logic [31:0]       cell_data [DEPTH];
    logic [NGRP*SCAN_GROUP-1:0] match_pad;
    logic [7:0]        grp_bits [NGRP];
    logic [7:0]        cur_bits;
    logic [GW+2:0]     hit_pos;

    assign accept = start && (state_reg == S_IDLE);
    assign key    = value;

    // chain of cells, position 0 is the head
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [31:0] left_data;
        logic [31:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = key;
        end
        else
        begin : g_mid_l
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_data = cell_data[i+1];
        end

        dvs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (ctrl),
            .wr    (tail_wr && (count_reg == CW'(i))),
            .valid (count_reg > CW'(i)),
            .key   (key),
            .left  (left_data),
            .right (right_data),
            .data  (cell_data[i]),
            .match (match_pad[i])
        );
    end

    // padding flags beyond the last cell never match
    if (NGRP * SCAN_GROUP > DEPTH)
    begin : g_pad
        assign match_pad[NGRP*SCAN_GROUP-1:DEPTH] = '0;
    end

    // group view of the match flags for the scan
    for (genvar g = 0; g < NGRP; g++)
    begin : g_grp
        assign grp_bits[g] = match_pad[g*SCAN_GROUP +: SCAN_GROUP];
    end

    assign cur_bits = grp_bits[grp_reg];
    assign hit_pos  = {grp_reg, first_set8(cur_bits)};

    // request decode and scan sequencing
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        grp_next    = grp_reg;
        done_next   = 1'b0;
        status_next = status_reg;
        found_next  = found_reg;
        pos_next    = pos_reg;
        ctrl        = '0;
        tail_wr     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    status_next = STATUS_OK;
                    found_next  = 1'b0;
                    pos_next    = 4'd0;
                    done_next   = 1'b1;
                    if (kind == KIND_PUSH_TAIL || kind == KIND_PUSH_HEAD)
                    begin
                        if (count_reg == CW'(DEPTH))
                        begin
                            status_next = STATUS_FULL;
                        end
                        else
                        begin
                            ctrl.shr   = (kind == KIND_PUSH_HEAD);
                            tail_wr    = (kind == KIND_PUSH_TAIL);
                            count_next = count_reg + CW'(1);
                        end
                    end
                    else if (kind == KIND_POP_HEAD || kind == KIND_POP_TAIL)
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STATUS_EMPTY;
                        end
                        else
                        begin
                            ctrl.shl   = (kind == KIND_POP_HEAD);
                            count_next = count_reg - CW'(1);
                        end
                    end
                    else if (kind == KIND_SEARCH)
                    begin
                        ctrl.cap   = 1'b1;
                        done_next  = 1'b0;
                        grp_next   = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (cur_bits != 8'd0)
                begin
                    found_next = 1'b1;
                    pos_next   = hit_pos[3:0];
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else if (grp_reg == GW'(NGRP - 1))
                begin
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    grp_next = grp_reg + GW'(1);
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            grp_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            grp_reg   <= grp_next;
            done_reg  <= done_next;
        end
    end

    // result beat payload
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        found_reg  <= found_next;
        pos_reg    <= pos_next;
    end

    assign busy           = (state_reg == S_SCAN);
    assign done           = done_reg;
    assign status         = status_reg;
    assign found          = found_reg;
    assign found_position = pos_reg;
    assign entry_count    = 5'(count_reg);

    // no result beat while a scan is running
    a_no_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !done)
        else $error("result beat during scan");

    // count never exceeds the chain length
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    // a refused push only when the chain is full
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_FULL) |-> (count_reg == CW'(DEPTH)))
        else $error("full status with free cells");

    // a match is always reported with ok status
    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && found) |-> (status == STATUS_OK))
        else $error("match reported with error status");

    // a search accepted leads into the scan
    a_search_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_SEARCH) |=> busy)
        else $error("search did not start a scan");

endmodule

// File: src/dvs_cell.sv
// ----------------------------------------------------------------------------
// dvs_cell
// One storage cell of the deque chain: holds the entry at a fixed position
// from the head, takes its neighbour's entry on a shift and compares its
// entry against the search key.
// ----------------------------------------------------------------------------
module dvs_cell
    import dvs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dvs_ctrl_t   ctrl,
    input  logic        wr,
    input  logic        valid,
    input  logic [31:0] key,
    input  logic [31:0] left,
    input  logic [31:0] right,
    output logic [31:0] data,
    output logic        match
);

    logic [31:0] data_reg;
    logic [31:0] data_next;
    logic        match_reg;
    logic        match_next;

    // entry update: shifts win over a tail write
    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.shr)
        begin
            data_next = left;
        end
        else if (ctrl.shl)
        begin
            data_next = right;
        end
        else if (wr)
        begin
            data_next = key;
        end
    end

    // compare flag, only held positions can match
    always_comb
    begin
        match_next = match_reg;
        if (ctrl.cap)
        begin
            match_next = valid && (data_reg == key);
        end
    end

    // stored entry, undefined until pushed
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg <= 1'b0;
        end
        else
        begin
            match_reg <= match_next;
        end
    end

    assign data  = data_reg;
    assign match = match_reg;

endmodule

// File: tb/tb_deque_with_value_search_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_deque_with_value_search_unit
// Self-checking bench for the deque with value search. A directed table walks
// the empty and full edges, the extreme values, spare request codes and
// duplicate matches. Random phases then fill, drain and search the store
// under varying sender gaps. Every result beat is checked field by field, in
// order of issue, against the typed table result or an in-bench ring model.
// ----------------------------------------------------------------------------
module tb_deque_with_value_search_unit;
    import dvs_pkg::*;

    localparam int unsigned CAPACITY     = 16;
    localparam int unsigned RANDOM_ITEMS = 1050;
    localparam int unsigned PHASE_LEN    = 50;

    // spare request codes, ignored by the block
    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    // random phase flavours
    localparam int unsigned MIX_FILL   = 0;
    localparam int unsigned MIX_DRAIN  = 1;
    localparam int unsigned MIX_EVEN   = 2;
    localparam int unsigned MIX_SEARCH = 3;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [3:0] position;
        logic [4:0] count;
    } dq_result_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] value;
        logic [4:0]         reps;
        logic               typed;
        dq_result_t         res;
    } plan_row_t;

    localparam int unsigned PLAN_ROWS = 25;

    // directed table; typed rows carry the expected result of the plain cases
    localparam plan_row_t PLAN [PLAN_ROWS] = '{
        '{KIND_POP_HEAD,  32'sh0000_0000, 5'd1,  1'b1, '{STATUS_EMPTY, 1'b0, 4'd0, 5'd0}},
        '{KIND_POP_TAIL,  32'sh0000_0000, 5'd1,  1'b1, '{STATUS_EMPTY, 1'b0, 4'd0, 5'd0}},
        '{KIND_SEARCH,    32'sh0000_0000, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd0}},
        '{KIND_PUSH_TAIL, 32'sh7fff_ffff, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd1}},
        '{KIND_PUSH_HEAD, 32'sh8000_0000, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd2}},
        '{KIND_SEARCH,    32'sh7fff_ffff, 5'd1,  1'b1, '{STATUS_OK,    1'b1, 4'd1, 5'd2}},
        '{KIND_SEARCH,    32'sh8000_0000, 5'd1,  1'b1, '{STATUS_OK,    1'b1, 4'd0, 5'd2}},
        '{KIND_SEARCH,    32'sh0000_0000, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd2}},
        '{KIND_RSVD5,     32'shffff_ffff, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd2}},
        '{KIND_RSVD6,     32'sh7fff_ffff, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd2}},
        '{KIND_RSVD7,     32'sh8000_0000, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd2}},
        '{KIND_PUSH_TAIL, 32'shffff_ffff, 5'd14, 1'b0, '0},
        '{KIND_PUSH_TAIL, 32'sh0000_0001, 5'd1,  1'b1, '{STATUS_FULL,  1'b0, 4'd0, 5'd16}},
        '{KIND_PUSH_HEAD, 32'sh0000_0001, 5'd1,  1'b1, '{STATUS_FULL,  1'b0, 4'd0, 5'd16}},
        '{KIND_SEARCH,    32'shffff_ffff, 5'd1,  1'b1, '{STATUS_OK,    1'b1, 4'd2, 5'd16}},
        '{KIND_SEARCH,    32'sh0000_3039, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd16}},
        '{KIND_POP_TAIL,  32'sh0000_0000, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd15}},
        '{KIND_POP_HEAD,  32'sh0000_0000, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd14}},
        '{KIND_SEARCH,    32'sh7fff_ffff, 5'd1,  1'b1, '{STATUS_OK,    1'b1, 4'd0, 5'd14}},
        '{KIND_PUSH_HEAD, 32'sh0000_0005, 5'd1,  1'b0, '0},
        '{KIND_PUSH_TAIL, 32'sh0000_0005, 5'd1,  1'b0, '0},
        '{KIND_SEARCH,    32'sh0000_0005, 5'd1,  1'b1, '{STATUS_OK,    1'b1, 4'd0, 5'd16}},
        '{KIND_POP_TAIL,  32'sh0000_0000, 5'd16, 1'b0, '0},
        '{KIND_POP_TAIL,  32'sh0000_0000, 5'd1,  1'b1, '{STATUS_EMPTY, 1'b0, 4'd0, 5'd0}},
        '{KIND_SEARCH,    32'shffff_ffff, 5'd1,  1'b1, '{STATUS_OK,    1'b0, 4'd0, 5'd0}}
    };

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [2:0]         kind;
    logic signed [31:0] value;
    logic               done;
    logic [1:0]         status;
    logic               found;
    logic [3:0]         found_position;
    logic [4:0]         entry_count;

    // typed expectation that travels with the current beat
    logic       plan_typed;
    dq_result_t plan_res;

    // model of the ring
    logic signed [31:0] ring [CAPACITY];
    logic [3:0]         ring_head;
    logic [4:0]         ring_held;

    dq_result_t         pending_results [$];
    logic signed [31:0] value_pool [8];
    bit                 idle_on;

    int unsigned failures;
    int unsigned n_beats;
    int unsigned n_results;
    int unsigned n_searches;
    int unsigned n_hits;
    int unsigned n_refused_push;
    int unsigned n_refused_pop;
    int unsigned n_peak_full;

    deque_with_value_search_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .value          (value),
        .done           (done),
        .status         (status),
        .found          (found),
        .found_position (found_position),
        .entry_count    (entry_count)
    );

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // apply one request to the ring model and return its result
    function automatic dq_result_t apply_request(logic [2:0] k, logic signed [31:0] v);
        dq_result_t r;
        logic [3:0] slot;
        r = '0;
        case (k)
            KIND_PUSH_TAIL, KIND_PUSH_HEAD:
            begin
                if (ring_held == 5'(CAPACITY))
                begin
                    r.status = STATUS_FULL;
                end
                else if (k == KIND_PUSH_TAIL)
                begin
                    slot = ring_head + ring_held[3:0];
                    ring[slot] = v;
                    ring_held = ring_held + 5'd1;
                end
                else
                begin
                    ring_head = ring_head - 4'd1;
                    ring[ring_head] = v;
                    ring_held = ring_held + 5'd1;
                end
            end
            KIND_POP_HEAD, KIND_POP_TAIL:
            begin
                if (ring_held == 5'd0)
                begin
                    r.status = STATUS_EMPTY;
                end
                else
                begin
                    if (k == KIND_POP_HEAD)
                    begin
                        ring_head = ring_head + 4'd1;
                    end
                    ring_held = ring_held - 5'd1;
                end
            end
            KIND_SEARCH:
            begin
                // walk from the tail end so the match nearest the head wins
                for (int i = int'(ring_held) - 1; i >= 0; i--)
                begin
                    slot = ring_head + 4'(i);
                    if (ring[slot] == v)
                    begin
                        r.found    = 1'b1;
                        r.position = 4'(i);
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = ring_held;
        return r;
    endfunction

    // accepted beats feed the model, result strobes are checked in order
    always @(posedge clk)
    begin
        dq_result_t got;
        dq_result_t want;
        dq_result_t pred;
        if (done)
        begin
            got = '{status, found, found_position, entry_count};
            n_results++;
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing outstanding: status %0d count %0d",
                       got.status, got.count);
                failures++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    failures++;
                end
                if (got.found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, got.found);
                    failures++;
                end
                if (got.position !== want.position)
                begin
                    $error("found_position: expected %0d, got %0d",
                           want.position, got.position);
                    failures++;
                end
                if (got.count !== want.count)
                begin
                    $error("entry_count: expected %0d, got %0d", want.count, got.count);
                    failures++;
                end
            end
        end
        if (rst_n && start && !busy)
        begin
            pred = apply_request(kind, value);
            want = plan_typed ? plan_res : pred;
            pending_results.push_back(want);
            n_beats++;
            if (kind == KIND_SEARCH)
            begin
                n_searches++;
                if (pred.found)
                begin
                    n_hits++;
                end
            end
            if (pred.status == STATUS_FULL)
            begin
                n_refused_push++;
            end
            if (pred.status == STATUS_EMPTY)
            begin
                n_refused_pop++;
            end
            if (pred.count == 5'(CAPACITY))
            begin
                n_peak_full++;
            end
        end
    end

    // drive one beat, hold it until taken, then idle for a drawn gap
    task automatic issue_request(logic [2:0] k, logic signed [31:0] v, logic typed,
                                 dq_result_t res);
        int unsigned gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        @(negedge clk);
        start      <= 1'b1;
        kind       <= k;
        value      <= v;
        plan_typed <= typed;
        plan_res   <= res;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        if (gap > 0)
        begin
            // idle with junk on the payload
            @(negedge clk);
            start <= 1'b0;
            kind  <= 3'($urandom);
            value <= $urandom;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // value source: mostly a small pool so searches hit, sometimes anything, else -2 to 1
    function automatic logic signed [31:0] draw_value();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            return value_pool[$urandom_range(0, 7)];
        end
        else if (r < 85)
        begin
            return $urandom;
        end
        return 32'($urandom_range(0, 3)) - 32'sd2;
    endfunction

    // request code per phase flavour
    function automatic logic [2:0] draw_kind(int unsigned mix);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            return 3'($urandom_range(5, 7));
        end
        case (mix)
            MIX_FILL:   r = (r < 70) ? 0 : (r < 85) ? 2 : 4;
            MIX_DRAIN:  r = (r < 20) ? 0 : (r < 80) ? 2 : 4;
            MIX_SEARCH: r = (r < 25) ? 0 : (r < 45) ? 2 : 4;
            default:    r = (r < 45) ? 0 : (r < 80) ? 2 : 4;
        endcase
        // both ends get equal use
        case (r)
            0:       return $urandom_range(0, 1) ? KIND_PUSH_TAIL : KIND_PUSH_HEAD;
            2:       return $urandom_range(0, 1) ? KIND_POP_HEAD : KIND_POP_TAIL;
            default: return KIND_SEARCH;
        endcase
    endfunction

    // limit on the whole run
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // stimulus
    initial
    begin
        int unsigned real_items;
        int unsigned phase;
        int unsigned mix;
        logic [2:0]  k;
        rst_n      = 1'b0;
        start      = 1'b0;
        kind       = KIND_PUSH_TAIL;
        value      = '0;
        plan_typed = 1'b0;
        plan_res   = '0;
        ring_head  = '0;
        ring_held  = '0;
        idle_on    = 1'b1;
        failures   = 0;
        n_beats    = 0;
        n_results  = 0;
        n_searches = 0;
        n_hits     = 0;
        n_refused_push = 0;
        n_refused_pop  = 0;
        n_peak_full    = 0;
        value_pool[0] = 32'sh7fff_ffff;
        value_pool[1] = 32'sh8000_0000;
        value_pool[2] = 32'sh0000_0000;
        value_pool[3] = 32'shffff_ffff;
        for (int i = 4; i < 8; i++)
        begin
            value_pool[i] = $urandom;
        end

        // reset
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed table
        foreach (PLAN[r])
        begin
            repeat (PLAN[r].reps)
            begin
                issue_request(PLAN[r].kind, PLAN[r].value, PLAN[r].typed, PLAN[r].res);
            end
        end

        // random phases
        real_items = 0;
        phase      = 0;
        while (real_items < RANDOM_ITEMS)
        begin
            mix     = $urandom_range(MIX_FILL, MIX_SEARCH);
            idle_on = ($urandom_range(0, 2) != 0);
            if (phase % 2 == 0)
            begin
                // every other phase one pool entry gets fresh content
                value_pool[$urandom_range(4, 7)] = $urandom;
            end
            repeat (PHASE_LEN)
            begin
                k = draw_kind(mix);
                issue_request(k, draw_value(), 1'b0, '0);
                if (k <= KIND_SEARCH)
                begin
                    real_items++;
                end
            end
            if (phase % 4 == 3)
            begin
                // let everything drain before going on
                @(negedge clk);
                start <= 1'b0;
                while (pending_results.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            phase++;
        end

        // drain and watch for stray strobes
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);

        $display("run: %0d beats, %0d results, %0d searches (%0d hits)",
                 n_beats, n_results, n_searches, n_hits);
        $display("edges: %0d refused pushes, %0d refused pops, %0d beats at full",
                 n_refused_push, n_refused_pop, n_peak_full);
        if (failures == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
